// File: src/assert_macros.svh
// Assertion macros shared by the matrix ring rotator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define MRR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define MRR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/mrr_pkg.sv
// Shared constants and control types of the matrix ring rotator.
package mrr_pkg;

	localparam int MAX_DIM   = 64;
	localparam int DIM_W     = 6;
	localparam int SIZE_W    = 7;
	localparam int ADDR_W    = 2 * DIM_W;
	localparam int MEM_DEPTH = MAX_DIM * MAX_DIM;
	localparam int DATA_W    = 32;
	localparam int SHIFT_W   = 31;
	localparam int LEN_W     = 8;
	localparam int CNT_W     = 5;
	localparam int CFG_IDX_W = 2;
	localparam int IN_W      = 48;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NUM_ROWS = 2'd0,
		REG_NUM_COLS = 2'd1,
		REG_SHIFT    = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic accept;
		logic ring_en;
		logic pos_en;
		logic div_step;
		logic map_en;
		logic coord_en;
		logic mem_we;
		logic mem_re;
		logic out_load;
	} mrr_cmd_t;

	typedef struct packed {
		logic in_range;
		logic is_read;
		logic mid;
		logic div_last;
		logic out_free;
	} mrr_stat_t;

endpackage

// File: src/mrr_ctrl.sv
// Controller state machine that sequences each request through the datapath.
`include "assert_macros.svh"

module mrr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  mrr_pkg::mrr_stat_t stat,
	output mrr_pkg::mrr_cmd_t  cmd
);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_RING  = 8'b0000_0010,
		ST_POS   = 8'b0000_0100,
		ST_DIV   = 8'b0000_1000,
		ST_MAP   = 8'b0001_0000,
		ST_COORD = 8'b0010_0000,
		ST_READ  = 8'b0100_0000,
		ST_DONE  = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid) begin
					state_d = ST_RING;
				end
			end
			ST_RING: begin
				cmd.ring_en = 1'b1;
				state_d     = ST_POS;
			end
			ST_POS: begin
				cmd.pos_en = 1'b1;
				cmd.mem_we = stat.in_range && !stat.is_read;
				if (!stat.in_range || !stat.is_read) begin
					state_d = ST_DONE;
				end else if (stat.mid) begin
					state_d = ST_READ;
				end else begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = ST_MAP;
				end
			end
			ST_MAP: begin
				cmd.map_en = 1'b1;
				state_d    = ST_COORD;
			end
			ST_COORD: begin
				cmd.coord_en = 1'b1;
				state_d      = ST_READ;
			end
			ST_READ: begin
				cmd.mem_re = 1'b1;
				state_d    = ST_DONE;
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	`MRR_ASSERT(a_load_free, cmd.out_load |-> stat.out_free, "result loaded into a full register")
	`MRR_ASSERT(a_we_inside, cmd.mem_we |-> (stat.in_range && !stat.is_read), "bad store write")
	`MRR_ASSERT_NEXT(a_accept_busy, cmd.accept, !in_ready, "accepted while still busy")

endmodule

// File: src/mrr_datapath.sv
// Datapath with configuration registers, ring arithmetic, serial remainder and matrix store.
`include "assert_macros.svh"

module mrr_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [mrr_pkg::IN_W-1:0]            in_data,
	input  mrr_pkg::mrr_cmd_t                   cmd,
	output mrr_pkg::mrr_stat_t                  stat,
	input  logic                                cfg_we,
	input  logic [mrr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mrr_pkg::SHIFT_W-1:0]         cfg_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [mrr_pkg::DATA_W-1:0]          out_data
);

	localparam int DW = mrr_pkg::DIM_W;
	localparam int SW = mrr_pkg::SIZE_W;
	localparam int LW = mrr_pkg::LEN_W;

	logic [SW-1:0]                  num_rows_q;
	logic [SW-1:0]                  num_cols_q;
	logic [mrr_pkg::SHIFT_W-1:0]    shift_q;

	logic                           op_q;
	logic [DW-1:0]                  row_q;
	logic [DW-1:0]                  col_q;
	logic signed [mrr_pkg::DATA_W-1:0] value_q;
	logic [mrr_pkg::ADDR_W-1:0]     addr_q;

	logic [SW-1:0]                  n_c, m_c, n_q, m_q;
	logic                           inside_c, inside_q, mid_c, mid_q;
	logic [SW-1:0]                  rdist_c, cdist_c, min1_c, min2_c, lw_c, half_c;
	logic [DW-1:0]                  l_q;

	logic [DW-1:0]                  ilast_c, jlast_c, a_c, b_c;
	logic [LW-1:0]                  len_c, p_c, a8_c, b8_c;
	logic [DW-1:0]                  ilast_q, jlast_q, a_q, b_q;
	logic [LW-1:0]                  len_q, p_q;

	logic [LW-1:0]                  rem_q;
	logic [mrr_pkg::CNT_W-1:0]      cnt_q;
	logic [LW:0]                    trial_c;

	logic [LW:0]                    qsum_c;
	logic [LW-1:0]                  q_q;

	logic [LW-1:0]                  qa_c, qab_c, qaab_c, ab_c, aab_c;
	logic [DW-1:0]                  si_c, sj_c;

	logic [mrr_pkg::DATA_W-1:0]     mem [mrr_pkg::MEM_DEPTH];
	logic [mrr_pkg::DATA_W-1:0]     rdata_q;

	logic                           out_valid_q;
	logic [mrr_pkg::DATA_W-1:0]     out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= SW'(mrr_pkg::MAX_DIM);
			num_cols_q <= SW'(mrr_pkg::MAX_DIM);
			shift_q    <= '0;
		end else if (cfg_we) begin
			case (mrr_pkg::cfg_reg_t'(cfg_index))
				mrr_pkg::REG_NUM_ROWS: num_rows_q <= cfg_data[SW-1:0];
				mrr_pkg::REG_NUM_COLS: num_cols_q <= cfg_data[SW-1:0];
				mrr_pkg::REG_SHIFT:    shift_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q    <= in_data[0];
			row_q   <= in_data[DW:1];
			col_q   <= in_data[2*DW:DW+1];
			value_q <= in_data[2*DW+mrr_pkg::DATA_W:2*DW+1];
		end
	end

	always_comb begin
		if (num_rows_q < SW'(2)) begin
			n_c = SW'(2);
		end else if (num_rows_q > SW'(mrr_pkg::MAX_DIM)) begin
			n_c = SW'(mrr_pkg::MAX_DIM);
		end else begin
			n_c = num_rows_q;
		end
		if (num_cols_q < SW'(2)) begin
			m_c = SW'(2);
		end else if (num_cols_q > SW'(mrr_pkg::MAX_DIM)) begin
			m_c = SW'(mrr_pkg::MAX_DIM);
		end else begin
			m_c = num_cols_q;
		end
		inside_c = ({1'b0, row_q} < n_c) && ({1'b0, col_q} < m_c);
		rdist_c  = n_c - SW'(1) - {1'b0, row_q};
		cdist_c  = m_c - SW'(1) - {1'b0, col_q};
		min1_c   = (row_q < col_q) ? {1'b0, row_q} : {1'b0, col_q};
		min2_c   = (rdist_c < cdist_c) ? rdist_c : cdist_c;
		lw_c     = (min1_c < min2_c) ? min1_c : min2_c;
		half_c   = ((n_c < m_c) ? n_c : m_c) >> 1;
		mid_c    = lw_c >= half_c;
	end

	always_ff @(posedge clk) begin
		if (cmd.ring_en) begin
			n_q      <= n_c;
			m_q      <= m_c;
			inside_q <= inside_c;
			mid_q    <= mid_c;
			l_q      <= lw_c[DW-1:0];
		end
	end

	always_comb begin
		ilast_c = DW'(n_q - SW'(1) - {1'b0, l_q});
		jlast_c = DW'(m_q - SW'(1) - {1'b0, l_q});
		a_c     = ilast_c - l_q;
		b_c     = jlast_c - l_q;
		a8_c    = LW'(a_c);
		b8_c    = LW'(b_c);
		len_c   = (a8_c << 1) + (b8_c << 1);
		if (col_q == l_q && row_q < ilast_c) begin
			p_c = LW'(row_q - l_q);
		end else if (row_q == ilast_c && col_q < jlast_c) begin
			p_c = a8_c + LW'(col_q - l_q);
		end else if (col_q == jlast_c && row_q > l_q) begin
			p_c = a8_c + b8_c + LW'(ilast_c - row_q);
		end else begin
			p_c = (a8_c << 1) + b8_c + LW'(jlast_c - col_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pos_en) begin
			ilast_q <= ilast_c;
			jlast_q <= jlast_c;
			a_q     <= a_c;
			b_q     <= b_c;
			len_q   <= len_c;
			p_q     <= p_c;
		end
	end

	assign trial_c = {rem_q, shift_q[cnt_q]};

	always_ff @(posedge clk) begin
		if (cmd.pos_en) begin
			rem_q <= '0;
			cnt_q <= mrr_pkg::CNT_W'(mrr_pkg::SHIFT_W - 1);
		end else if (cmd.div_step) begin
			if (trial_c >= {1'b0, len_q}) begin
				rem_q <= LW'(trial_c - {1'b0, len_q});
			end else begin
				rem_q <= LW'(trial_c);
			end
			cnt_q <= cnt_q - mrr_pkg::CNT_W'(1);
		end
	end

	assign qsum_c = {1'b0, p_q} + {1'b0, len_q} - {1'b0, rem_q};

	always_ff @(posedge clk) begin
		if (cmd.map_en) begin
			if (qsum_c >= {1'b0, len_q}) begin
				q_q <= LW'(qsum_c - {1'b0, len_q});
			end else begin
				q_q <= LW'(qsum_c);
			end
		end
	end

	always_comb begin
		ab_c   = LW'(a_q) + LW'(b_q);
		aab_c  = ab_c + LW'(a_q);
		qa_c   = q_q - LW'(a_q);
		qab_c  = q_q - ab_c;
		qaab_c = q_q - aab_c;
		if (q_q < LW'(a_q)) begin
			si_c = l_q + DW'(q_q);
			sj_c = l_q;
		end else if (q_q < ab_c) begin
			si_c = ilast_q;
			sj_c = l_q + DW'(qa_c);
		end else if (q_q < aab_c) begin
			si_c = ilast_q - DW'(qab_c);
			sj_c = jlast_q;
		end else begin
			si_c = l_q;
			sj_c = jlast_q - DW'(qaab_c);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			addr_q <= {in_data[DW:1], in_data[2*DW:DW+1]};
		end else if (cmd.coord_en) begin
			addr_q <= {si_c, sj_c};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_we) begin
			mem[addr_q] <= value_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_re) begin
			rdata_q <= mem[addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q <= (op_q == mrr_pkg::OP_READ && inside_q) ? rdata_q : '0;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_data       = out_data_q;
	assign stat.in_range  = inside_q;
	assign stat.is_read   = (op_q == mrr_pkg::OP_READ);
	assign stat.mid       = mid_q;
	assign stat.div_last  = (cnt_q == '0);
	assign stat.out_free  = !out_valid_q || out_ready;

	`MRR_ASSERT(a_pos_range, cmd.div_step |-> (p_q < len_q), "ring position beyond ring length")
	`MRR_ASSERT(a_src_range, cmd.coord_en |-> (q_q < len_q), "source position beyond ring length")
	`MRR_ASSERT_NEXT(a_rem_range, cmd.div_step, rem_q < len_q, "remainder not below ring length")

endmodule

// File: src/matrix_ring_rotator.sv
// Top level of the matrix ring rotator: stored matrix read back with rotated rings.
//
//   Channel   Direction  Signals                       Contents
//   s_*       in         s_tvalid s_tready s_tdata      one write or read request
//   m_*       out        m_tvalid m_tready m_tdata      one result word per request
//   cfg_*     in         cfg_we cfg_index cfg_data      register writes
//
// A write, or any request outside the configured size, goes through the ring and position
// steps to its result. A read of a rotated ring also computes the bit-serial
// remainder of the shift by the ring length, one bit per cycle over 31 bits.
// A read on the unrotated middle line skips the remainder and reads the store directly.
// The output register holds a result until it is taken, and a new request is accepted
// meanwhile; the block waits in its last step only while that register is full and not taken.
// Reset clears control state and shift, sets sizes to 64; store is undefined until written.
module matrix_ring_rotator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// Fields from bit 0: op (1), row (6), col (6), value (32), zero padding (3).
	input  logic [mrr_pkg::IN_W-1:0]          s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// Fields from bit 0: data (32).
	output logic [mrr_pkg::DATA_W-1:0]        m_tdata,
	input  logic                              cfg_we,
	input  logic [mrr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mrr_pkg::SHIFT_W-1:0]       cfg_data
);

	mrr_pkg::mrr_cmd_t  cmd;
	mrr_pkg::mrr_stat_t stat;

	mrr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	mrr_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (s_tdata),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule
